// ===== hdl/i2crtc_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C RTC sequencer package
// Shared types, codes and constants of the I2C clock-chip transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crtc_pkg;

    // Number of set-up bytes sent in a write transfer and bytes in a read frame.
    localparam int INIT_COUNT  = 8;
    localparam int FRAME_BYTES = 7;
    localparam int FRAME_BITS  = 56;
    localparam int STORE_DEPTH = 7;

    // Reset values of the configuration registers.
    localparam logic [6:0]  DEV_ADDR_RST   = 7'd104;
    localparam logic [63:0] INIT_BYTES_RST = 64'd1159977092248977408;

    // Configuration register indexes.
    localparam logic CFG_DEV_ADDR   = 1'b0;
    localparam logic CFG_INIT_BYTES = 1'b1;

    // Request types.
    localparam logic [1:0] REQ_BEGIN_WR = 2'd0;
    localparam logic [1:0] REQ_BEGIN_RD = 2'd1;
    localparam logic [1:0] REQ_RESTART  = 2'd2;
    localparam logic [1:0] REQ_STATUS   = 2'd3;

    // Two-wire controller status codes.
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RESTART   = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK = 8'h48;
    localparam logic [7:0] ST_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_RX_NACK   = 8'h58;
    localparam logic [7:0] PTR_ZERO     = 8'h00;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [3:0] {
        OP_BEGIN_WR,
        OP_BEGIN_RD,
        OP_RESTART,
        OP_ADDR,
        OP_PTR,
        OP_STOP,
        OP_TX_NEXT,
        OP_ACK,
        OP_RX_ACK,
        OP_RX_LAST,
        OP_NONE
    } t_op;

    // Action codes for the bus controller.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_SEND  = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_ACK   = 3'd3,
        ACT_NACK  = 3'd4,
        ACT_START = 3'd5
    } t_action;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        t_action                 action;
        logic [7:0]              tx_byte;
        logic                    done_res;
        logic [FRAME_BITS-1:0]   frame;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/i2c_rtc_transfer_sequencer.sv =====
// Path: a request is registered in the front end's command queue, then executed
//   by the back end and registered in its result queue before it reaches the output
//   ports; a full result queue holds it in the command queue.
// Throughput: one request per cycle while neither queue is full.
// Reset: synchronous, active low; empties both queues, clears the sequencing
//   state and restores the register defaults. The receive store is not cleared.
// ----------------------------------------------------------------------------
// I2C RTC transfer sequencer
// Turns requests and two-wire controller status events into bus actions for
// writing set-up bytes to a real-time clock chip and reading back its frame.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rtc_transfer_sequencer (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Configuration write port: index 0 is the device address, 1 the set-up bytes.
    input  wire          i_cfg_we,
    input  wire          i_cfg_index,
    input  wire  [63:0]  i_cfg_data,
    // Request side, a queue write port.
    input  wire          push,
    output logic         full,
    input  wire  [1:0]   i_req_type,
    input  wire  [7:0]   i_status_code,
    input  wire  [7:0]   i_rx_byte,
    // Result side, a queue read port.
    output logic         empty,
    input  wire          pop,
    output logic [2:0]   o_action,
    output logic [7:0]   o_tx_byte,
    output logic         o_done_res,
    output logic [55:0]  o_frame
);
    import i2crtc_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;
    t_res res;

    // The front end decodes each request into an operation the moment it is
    // transferred in, so the back end never looks at raw status codes.
    i2crtc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_req_type    (i_req_type),
        .i_status_code (i_status_code),
        .i_rx_byte     (i_rx_byte),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    // The back end runs one operation per cycle whenever its result queue has
    // room, updating the transfer state and pushing exactly one result.
    i2crtc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .o_res       (res),
        .i_pop       (pop)
    );

    assign o_action   = res.action;
    assign o_tx_byte  = res.tx_byte;
    assign o_done_res = res.done_res;
    assign o_frame    = res.frame;

endmodule

`default_nettype wire

// ===== hdl/i2crtc_front.sv =====
// ----------------------------------------------------------------------------
// I2C RTC sequencer front end
// Classifies request items into operations and buffers them in a two-entry
// command queue ahead of the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crtc_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    output logic               o_full,
    input  wire  [1:0]         i_req_type,
    input  wire  [7:0]         i_status_code,
    input  wire  [7:0]         i_rx_byte,
    output logic               o_cmd_valid,
    output i2crtc_pkg::t_cmd   o_cmd,
    input  wire                i_cmd_pop
);
    import i2crtc_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_op        op;
    logic       wr_en;
    logic       rd_en;

    // Map the request into a single operation code.
    always_comb begin
        unique case (i_req_type)
            REQ_BEGIN_WR: op = OP_BEGIN_WR;
            REQ_BEGIN_RD: op = OP_BEGIN_RD;
            REQ_RESTART:  op = OP_RESTART;
            REQ_STATUS: begin
                unique case (i_status_code)
                    ST_START, ST_RESTART:                   op = OP_ADDR;
                    ST_SLAW_ACK:                            op = OP_PTR;
                    ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK: op = OP_STOP;
                    ST_DATA_ACK:                            op = OP_TX_NEXT;
                    ST_SLAR_ACK:                            op = OP_ACK;
                    ST_RX_ACK:                              op = OP_RX_ACK;
                    ST_RX_NACK:                             op = OP_RX_LAST;
                    default:                                op = OP_NONE;
                endcase
            end
            default: op = OP_NONE;
        endcase
    end

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = wr_en ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = rd_en ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= '{op: op, rx_byte: i_rx_byte};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/i2crtc_back.sv =====
// ----------------------------------------------------------------------------
// I2C RTC sequencer back end
// Carries out classified operations against the transfer state, holds the
// configuration registers and the receive store, and queues the results.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crtc_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_index,
    input  wire  [63:0]        i_cfg_data,
    input  wire                i_cmd_valid,
    input  wire  i2crtc_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    output i2crtc_pkg::t_res   o_res,
    input  wire                i_pop
);
    import i2crtc_pkg::*;

    logic [6:0]  r_dev_addr;
    logic [63:0] r_init_bytes;

    logic        r_read_phase, n_read_phase;
    logic        r_addr_step, n_addr_step;
    logic [3:0]  r_init_count, n_init_count;
    logic [2:0]  r_rx_count, n_rx_count;
    logic [7:0]  r_rx_store [STORE_DEPTH];

    t_res        r_q [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;

    logic        exec;
    logic        rd_en;
    logic        store_ok;
    logic        store_en;
    t_res        res;
    logic [FRAME_BITS-1:0] frame;

    assign exec      = i_cmd_valid && (r_count != 2'd2);
    assign o_cmd_pop = exec;
    assign o_empty   = (r_count == 2'd0);
    assign o_res     = r_q[r_rd_ptr];
    assign rd_en     = i_pop && !o_empty;

    // A received byte is kept only while the frame still has room.
    assign store_ok = ({1'b0, r_rx_count} < 4'(FRAME_BYTES)) &&
                      ({1'b0, r_rx_count} < 4'(STORE_DEPTH));

    // Frame as seen after the byte of this step has been stored.
    always_comb begin
        frame = '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (i < FRAME_BYTES) begin
                if (store_ok && (r_rx_count == 3'(i))) begin
                    frame[8*i +: 8] = i_cmd.rx_byte;
                end else begin
                    frame[8*i +: 8] = r_rx_store[i];
                end
            end
        end
    end

    always_comb begin
        n_read_phase = r_read_phase;
        n_addr_step  = r_addr_step;
        n_init_count = r_init_count;
        n_rx_count   = r_rx_count;
        store_en     = 1'b0;
        res          = '{action: ACT_NONE, tx_byte: '0, done_res: 1'b0, frame: '0};
        unique case (i_cmd.op)
            OP_BEGIN_WR: begin
                n_addr_step  = 1'b0;
                n_init_count = '0;
                n_read_phase = 1'b0;
                res.action   = ACT_START;
            end
            OP_BEGIN_RD: begin
                n_addr_step  = 1'b0;
                n_rx_count   = '0;
                n_read_phase = 1'b1;
                res.action   = ACT_START;
            end
            OP_RESTART: res.action = ACT_START;
            OP_ADDR: begin
                res.tx_byte = {r_dev_addr, r_addr_step};
                res.action  = ACT_SEND;
                n_addr_step = 1'b1;
            end
            OP_PTR: begin
                res.tx_byte = PTR_ZERO;
                res.action  = ACT_SEND;
            end
            OP_STOP: res.action = ACT_STOP;
            OP_TX_NEXT: begin
                if (!r_read_phase && (r_init_count < 4'(INIT_COUNT))) begin
                    res.tx_byte  = r_init_bytes[8*r_init_count[2:0] +: 8];
                    res.action   = ACT_SEND;
                    n_init_count = r_init_count + 4'd1;
                end else begin
                    res.action   = ACT_STOP;
                    res.done_res = 1'b1;
                end
            end
            OP_ACK: res.action = ACT_ACK;
            OP_RX_ACK: begin
                res.action = (({1'b0, r_rx_count} + 4'd2) < 4'(FRAME_BYTES)) ?
                             ACT_ACK : ACT_NACK;
                store_en   = store_ok;
                if (store_ok) begin
                    n_rx_count = r_rx_count + 3'd1;
                end
            end
            OP_RX_LAST: begin
                store_en     = store_ok;
                n_rx_count   = '0;
                res.action   = ACT_STOP;
                res.done_res = 1'b1;
                res.frame    = frame;
            end
            OP_NONE: res.action = ACT_NONE;
            default: res.action = ACT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= DEV_ADDR_RST;
            r_init_bytes <= INIT_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEV_ADDR:   r_dev_addr   <= i_cfg_data[6:0];
                CFG_INIT_BYTES: r_init_bytes <= i_cfg_data;
                default:        r_dev_addr   <= r_dev_addr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_phase <= 1'b0;
            r_addr_step  <= 1'b0;
            r_init_count <= '0;
            r_rx_count   <= '0;
        end else if (exec) begin
            r_read_phase <= n_read_phase;
            r_addr_step  <= n_addr_step;
            r_init_count <= n_init_count;
            r_rx_count   <= n_rx_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && store_en) begin
            r_rx_store[r_rx_count] <= i_cmd.rx_byte;
        end
    end

    // Two-entry result queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (exec) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, exec} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_q[r_wr_ptr] <= res;
        end
    end

endmodule

`default_nettype wire
